/* design/orot_pkg.sv */
// Shared types, widths and helper functions for the oriented rectangle overlap test.
package orot_pkg;

   localparam int POS_W      = 20;   // Q16.4 centre coordinate
   localparam int DIR_W      = 16;   // Q1.14 direction component
   localparam int SIZE_W     = 19;   // Q15.4 full width or height
   localparam int DIFF_W     = POS_W + 1;
   localparam int DOT_W      = 2 * DIR_W;          // one direction product
   localparam int PROJ_W     = 2 * DIR_W;          // magnitude of a direction dot product
   localparam int MIX_W      = DIFF_W + DIR_W;     // centre difference times direction
   localparam int DIST_W     = MIX_W;              // magnitude of a projected distance
   localparam int TERM_W     = SIZE_W + PROJ_W;    // one projected extent
   localparam int EXT_W      = TERM_W + 2;         // sum of three extents
   localparam int LHS_SHIFT  = 15;                 // doubling plus the Q.18 to Q.32 step
   localparam int LHS_W      = DIST_W + LHS_SHIFT;
   localparam int NUM_AXES   = 4;
   localparam int NUM_TERMS  = 3;
   localparam int REQ_TDATA_W = 224;
   localparam int RSP_TDATA_W = 8;

   typedef struct packed {
      logic [SIZE_W-1:0] right_height;
      logic [SIZE_W-1:0] right_width;
      logic signed [DIR_W-1:0] right_sin;
      logic signed [DIR_W-1:0] right_cos;
      logic signed [POS_W-1:0] right_center_y;
      logic signed [POS_W-1:0] right_center_x;
      logic [SIZE_W-1:0] left_height;
      logic [SIZE_W-1:0] left_width;
      logic signed [DIR_W-1:0] left_sin;
      logic signed [DIR_W-1:0] left_cos;
      logic signed [POS_W-1:0] left_center_y;
      logic signed [POS_W-1:0] left_center_x;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] left_width;
      logic [SIZE_W-1:0] left_height;
      logic [SIZE_W-1:0] right_width;
      logic [SIZE_W-1:0] right_height;
   } size_type;

   // Everything the per-axis compare needs, shared by all four axes.
   typedef struct packed {
      logic [DIST_W-1:0] dist_left_up;
      logic [DIST_W-1:0] dist_right_up;
      logic [DIST_W-1:0] dist_left_right;
      logic [DIST_W-1:0] dist_right_right;
      logic [PROJ_W-1:0] mag_dot;     // |left_right . right_right|
      logic [PROJ_W-1:0] mag_cross;   // |left_right x right_right|
      logic [PROJ_W-1:0] norm_left;   // |left_right|^2
      logic [PROJ_W-1:0] norm_right;  // |right_right|^2
      size_type          size;
   } geom_type;

   typedef struct packed {
      logic [DIST_W-1:0]                   dist_mag;
      logic [NUM_TERMS-1:0][SIZE_W-1:0]    size;
      logic [NUM_TERMS-1:0][PROJ_W-1:0]    proj;
   } axis_in_type;

   function automatic logic [PROJ_W-1:0] abs_dot(input logic signed [DOT_W:0] v);
      logic signed [DOT_W:0] n;
      n = (v < 0) ? -v : v;
      return n[PROJ_W-1:0];
   endfunction

   function automatic logic [DIST_W-1:0] abs_mix(input logic signed [MIX_W:0] v);
      logic signed [MIX_W:0] n;
      n = (v < 0) ? -v : v;
      return n[DIST_W-1:0];
   endfunction

endpackage

/* design/orot_front.sv */
// Front pipeline: centre difference, direction products and projected distances.
module orot_front (
   input  logic              clock,
   input  logic              enable,
   input  orot_pkg::req_type req,
   output orot_pkg::geom_type geom
);
   import orot_pkg::*;

   // stage 1
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [DIR_W-1:0]  lc_ff, ls_ff, rc_ff, rs_ff;
   logic signed [DOT_W-1:0]  p_lcrc_ff, p_lsrs_ff, p_lcrs_ff, p_lsrc_ff;
   logic signed [DOT_W-1:0]  p_lclc_ff, p_lsls_ff, p_rcrc_ff, p_rsrs_ff;
   size_type                 size1_ff;
   // stage 2
   logic signed [DOT_W:0]    dot_ff, cross_ff, norm_l_ff, norm_r_ff;
   logic signed [MIX_W-1:0]  m_lsdx_ff, m_lcdy_ff, m_rsdx_ff, m_rcdy_ff;
   logic signed [MIX_W-1:0]  m_lcdx_ff, m_lsdy_ff, m_rcdx_ff, m_rsdy_ff;
   size_type                 size2_ff;
   // stage 3
   geom_type                 geom_ff;
   geom_type                 geom_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff     <= DIFF_W'(req.left_center_x) - DIFF_W'(req.right_center_x);
         dy_ff     <= DIFF_W'(req.left_center_y) - DIFF_W'(req.right_center_y);
         lc_ff     <= req.left_cos;
         ls_ff     <= req.left_sin;
         rc_ff     <= req.right_cos;
         rs_ff     <= req.right_sin;
         p_lcrc_ff <= req.left_cos * req.right_cos;
         p_lsrs_ff <= req.left_sin * req.right_sin;
         p_lcrs_ff <= req.left_cos * req.right_sin;
         p_lsrc_ff <= req.left_sin * req.right_cos;
         p_lclc_ff <= req.left_cos * req.left_cos;
         p_lsls_ff <= req.left_sin * req.left_sin;
         p_rcrc_ff <= req.right_cos * req.right_cos;
         p_rsrs_ff <= req.right_sin * req.right_sin;
         size1_ff  <= '{left_width: req.left_width, left_height: req.left_height,
                        right_width: req.right_width, right_height: req.right_height};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dot_ff    <= (DOT_W+1)'(p_lcrc_ff) + (DOT_W+1)'(p_lsrs_ff);
         cross_ff  <= (DOT_W+1)'(p_lcrs_ff) - (DOT_W+1)'(p_lsrc_ff);
         norm_l_ff <= (DOT_W+1)'(p_lclc_ff) + (DOT_W+1)'(p_lsls_ff);
         norm_r_ff <= (DOT_W+1)'(p_rcrc_ff) + (DOT_W+1)'(p_rsrs_ff);
         m_lsdx_ff <= dx_ff * ls_ff;
         m_lcdy_ff <= dy_ff * lc_ff;
         m_rsdx_ff <= dx_ff * rs_ff;
         m_rcdy_ff <= dy_ff * rc_ff;
         m_lcdx_ff <= dx_ff * lc_ff;
         m_lsdy_ff <= dy_ff * ls_ff;
         m_rcdx_ff <= dx_ff * rc_ff;
         m_rsdy_ff <= dy_ff * rs_ff;
         size2_ff  <= size1_ff;
      end
   end

   always_comb begin
      geom_in.dist_left_up     = abs_mix((MIX_W+1)'(m_lcdy_ff) - (MIX_W+1)'(m_lsdx_ff));
      geom_in.dist_right_up    = abs_mix((MIX_W+1)'(m_rcdy_ff) - (MIX_W+1)'(m_rsdx_ff));
      geom_in.dist_left_right  = abs_mix((MIX_W+1)'(m_lcdx_ff) + (MIX_W+1)'(m_lsdy_ff));
      geom_in.dist_right_right = abs_mix((MIX_W+1)'(m_rcdx_ff) + (MIX_W+1)'(m_rsdy_ff));
      geom_in.mag_dot          = abs_dot(dot_ff);
      geom_in.mag_cross        = abs_dot(cross_ff);
      geom_in.norm_left        = abs_dot(norm_l_ff);
      geom_in.norm_right       = abs_dot(norm_r_ff);
      geom_in.size             = size2_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

/* design/orot_axis.sv */
// Per-axis back end: projected extents, their sum and the separation compare.
module orot_axis (
   input  logic                  clock,
   input  logic                  enable,
   input  orot_pkg::axis_in_type term,
   output logic                  holds
);
   import orot_pkg::*;

   logic [NUM_TERMS-1:0][TERM_W-1:0] prod_ff;
   logic [DIST_W-1:0]                dist_ff;
   logic [EXT_W-1:0]                 ext_ff;
   logic [LHS_W-1:0]                 lhs_ff;
   logic                             holds_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NUM_TERMS; k++) begin
            prod_ff[k] <= TERM_W'(term.size[k]) * TERM_W'(term.proj[k]);
         end
         dist_ff  <= term.dist_mag;
         ext_ff   <= EXT_W'(prod_ff[0]) + EXT_W'(prod_ff[1]) + EXT_W'(prod_ff[2]);
         lhs_ff   <= {dist_ff, LHS_SHIFT'(0)};
         // tie counts as overlap
         holds_ff <= !(EXT_W'(lhs_ff) > ext_ff);
      end
   end

   assign holds = holds_ff;

endmodule

/* design/oriented_rect_overlap_test.sv */
// Top level of the oriented rectangle overlap test (2D separating axis test).
// Throughput: one box pair per cycle; a stall from rsp_tready freezes all stages.
// Stages: difference and direction products, distance products, magnitudes,
// extent products, extent sum, compare, output register.
// Reset clears the valid bits and holds req_tready low; the data path keeps its contents.
module oriented_rect_overlap_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // from bit 0: left_center_x, left_center_y, left_cos, left_sin, left_width,
   // left_height, right_center_x, right_center_y, right_cos, right_sin,
   // right_width, right_height, zero fill
   input  logic [orot_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // from bit 0: overlap, zero fill
   output logic [orot_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import orot_pkg::*;

   localparam int PIPE_STAGES = 6;

   req_type                  req;
   geom_type                 geom;
   axis_in_type              axis_in [NUM_AXES];
   logic [NUM_AXES-1:0]      holds;
   logic                     enable;
   logic [PIPE_STAGES-1:0]   valid_ff;
   logic                     rsp_valid_ff;
   logic                     overlap_ff;

   // Unpack the request transaction; the struct order matches tdata from bit 0.
   assign req = req_type'(req_tdata[$bits(req_type)-1:0]);

   // Global advance: the whole pipe moves unless a result waits and is not taken.
   // Refuse transactions while reset is high so none is dropped.
   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable && !reset;

   orot_front u_front (
      .clock  (clock),
      .enable (enable),
      .req    (req),
      .geom   (geom)
   );

   // Axis dot products collapse to four shared magnitudes:
   //   left up   : left_height*|L|^2, right_width*|cross|, right_height*|dot|
   //   right up  : left_width*|cross|, left_height*|dot|, right_height*|R|^2
   //   left right: left_width*|L|^2, right_width*|dot|, right_height*|cross|
   //   right right: left_width*|dot|, left_height*|cross|, right_width*|R|^2
   // The axis that is a box's own perpendicular direction projects zero.
   always_comb begin
      axis_in[0].dist_mag = geom.dist_left_up;
      axis_in[0].size[0]  = geom.size.left_height;
      axis_in[0].proj[0]  = geom.norm_left;
      axis_in[0].size[1]  = geom.size.right_width;
      axis_in[0].proj[1]  = geom.mag_cross;
      axis_in[0].size[2]  = geom.size.right_height;
      axis_in[0].proj[2]  = geom.mag_dot;

      axis_in[1].dist_mag = geom.dist_right_up;
      axis_in[1].size[0]  = geom.size.left_width;
      axis_in[1].proj[0]  = geom.mag_cross;
      axis_in[1].size[1]  = geom.size.left_height;
      axis_in[1].proj[1]  = geom.mag_dot;
      axis_in[1].size[2]  = geom.size.right_height;
      axis_in[1].proj[2]  = geom.norm_right;

      axis_in[2].dist_mag = geom.dist_left_right;
      axis_in[2].size[0]  = geom.size.left_width;
      axis_in[2].proj[0]  = geom.norm_left;
      axis_in[2].size[1]  = geom.size.right_width;
      axis_in[2].proj[1]  = geom.mag_dot;
      axis_in[2].size[2]  = geom.size.right_height;
      axis_in[2].proj[2]  = geom.mag_cross;

      axis_in[3].dist_mag = geom.dist_right_right;
      axis_in[3].size[0]  = geom.size.left_width;
      axis_in[3].proj[0]  = geom.mag_dot;
      axis_in[3].size[1]  = geom.size.left_height;
      axis_in[3].proj[1]  = geom.mag_cross;
      axis_in[3].size[2]  = geom.size.right_width;
      axis_in[3].proj[2]  = geom.norm_right;
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      orot_axis u_axis (
         .clock  (clock),
         .enable (enable),
         .term   (axis_in[a]),
         .holds  (holds[a])
      );
   end

   // Valid bits travel beside the data; hold everything on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= {valid_ff[PIPE_STAGES-2:0], req_tvalid};
         rsp_valid_ff <= valid_ff[PIPE_STAGES-1];
      end
   end

   // Overlap only when no axis separates the boxes.
   always_ff @(posedge clock) begin
      if (enable) begin
         overlap_ff <= &holds;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-1)'(0), overlap_ff};

   // An accepted transaction followed by unbroken advance through the pipe produces a result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 req_tready ##1 req_tready ##1 req_tready
         ##1 req_tready ##1 req_tready ##1 req_tready |=> rsp_tvalid)
      else $error("accepted transaction did not reach the output in time");

   // A stall freezes the valid bits of every stage.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   // An empty pipe with no new transaction cannot invent a result.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0 && !rsp_tvalid && !req_tvalid) |=> !rsp_tvalid)
      else $error("result appeared without an accepted transaction");

endmodule
